[rtl/mm2a_pkg.sv]
`timescale 1ns / 1ps

package mm2a_pkg;

    localparam logic [31:0] MmMul      = 32'h5bd1e995;
    localparam int unsigned MmShift    = 24;
    localparam int unsigned FinShift1  = 13;
    localparam int unsigned FinShift2  = 15;
    localparam logic [31:0] SeedReset  = 32'd33;
    localparam logic [2:0]  FullCount  = 3'd4;

    // k register operation
    typedef enum logic [2:0] {
        K_HOLD = 3'd0,
        K_MUL  = 3'd1,   // k = k * M
        K_MIX  = 3'd2,   // k = (k ^ k >> 24) * M
        K_ZERO = 3'd3,   // k = 0 (empty tail after a full last word)
        K_LEN  = 3'd4    // k = byte length
    } k_op_t;

    typedef struct packed {
        logic  load;     // beat taken on the word channel
        logic  fresh;    // first beat of a string: start from seed, length 0
        k_op_t k_op;
        logic  h_mul;    // h = h * M ^ k
        logic  fin;      // h = (h ^ h >> 13) * M
        logic  emit;     // load output register
    } mm2a_cmd_t;

    typedef struct packed {
        logic last;      // payload of waiting beat: last flag
        logic full;      // payload of waiting beat: byte_count >= 4
        logic out_busy;  // output register holds a beat not yet taken
    } mm2a_status_t;

endpackage

[rtl/mm2a_ifs.sv]
`timescale 1ns / 1ps

interface mm2a_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;

    modport source (output valid, data_word, byte_count, last, input ready);
    modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface mm2a_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

interface mm2a_seed_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_seed;

    modport source (output valid, hash_seed, input ready);
    modport sink   (input valid, hash_seed, output ready);
endinterface

[rtl/mm2a_datapath.sv]
`timescale 1ns / 1ps

module mm2a_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           data_word,
    input  logic [2:0]            byte_count,
    input  logic                  last,
    input  logic                  seed_valid,
    output logic                  seed_ready,
    input  logic [31:0]           hash_seed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           hash_value,
    input  mm2a_pkg::mm2a_cmd_t   cmd,
    output mm2a_pkg::mm2a_status_t st
);

    logic [31:0] seed_reg;
    logic [31:0] h_reg;
    logic [31:0] k_reg;
    logic [31:0] len_reg;
    logic [31:0] out_reg;
    logic        out_valid_reg;

    logic [2:0]  count_sat;
    logic [31:0] tail;
    logic [31:0] len_add;
    logic [31:0] mul_a;
    logic [31:0] prod;
    logic [31:0] h_fin;

    // saturate count; only meaningful on a last beat
    assign count_sat = (byte_count > mm2a_pkg::FullCount) ? mm2a_pkg::FullCount : byte_count;

    always_comb
    begin
        unique case (count_sat[1:0])
            2'd0:    tail = 32'h0000_0000;
            2'd1:    tail = {24'h000000, data_word[7:0]};
            2'd2:    tail = {16'h0000, data_word[15:0]};
            default: tail = {8'h00, data_word[23:0]};
        endcase
    end

    assign len_add = last ? {29'd0, count_sat} : 32'd4;

    // single shared multiplier by the mixing constant
    always_comb
    begin
        priority if (cmd.k_op == mm2a_pkg::K_MIX)
            mul_a = k_reg ^ (k_reg >> mm2a_pkg::MmShift);
        else if (cmd.h_mul)
            mul_a = h_reg;
        else if (cmd.fin)
            mul_a = h_reg ^ (h_reg >> mm2a_pkg::FinShift1);
        else
            mul_a = k_reg;
    end

    assign prod = mul_a * mm2a_pkg::MmMul;

    assign h_fin = h_reg ^ (h_reg >> mm2a_pkg::FinShift2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= mm2a_pkg::SeedReset;
        else if (seed_valid)
            seed_reg <= hash_seed;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            h_reg   <= cmd.fresh ? seed_reg : h_reg;
            len_reg <= (cmd.fresh ? 32'd0 : len_reg) + len_add;
            k_reg   <= (last && !(count_sat == mm2a_pkg::FullCount)) ? tail : data_word;
        end
        else
        begin
            if (cmd.h_mul)
                h_reg <= prod ^ k_reg;
            else if (cmd.fin)
                h_reg <= prod;

            unique case (cmd.k_op)
                mm2a_pkg::K_MUL,
                mm2a_pkg::K_MIX:  k_reg <= prod;
                mm2a_pkg::K_ZERO: k_reg <= 32'd0;
                mm2a_pkg::K_LEN:  k_reg <= len_reg;
                default:          k_reg <= k_reg;
            endcase
        end

        if (cmd.emit)
            out_reg <= (h_fin == 32'd0) ? 32'd1 : h_fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign seed_ready  = 1'b1;
    assign out_valid   = out_valid_reg;
    assign hash_value  = out_reg;

    assign st.last     = last;
    assign st.full     = (count_sat == mm2a_pkg::FullCount);
    assign st.out_busy = out_valid_reg && !out_ready;

endmodule

[rtl/mm2a_ctrl.sv]
`timescale 1ns / 1ps

module mm2a_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mm2a_pkg::mm2a_status_t st,
    output mm2a_pkg::mm2a_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_K1   = 6'b000010,
        ST_K2   = 6'b000100,
        ST_HM   = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    // which mix is running
    typedef enum logic [1:0] {
        PH_WORD  = 2'd0,
        PH_BLOCK = 2'd1,
        PH_TAIL  = 2'd2,
        PH_LEN   = 2'd3
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   in_string_reg, in_string_next;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        in_string_next = in_string_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.k_op       = mm2a_pkg::K_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.fresh      = !in_string_reg;
                    in_string_next = 1'b1;
                    state_next     = ST_K1;
                    priority if (!st.last)
                        phase_next = PH_WORD;
                    else if (st.full)
                        phase_next = PH_BLOCK;
                    else
                        phase_next = PH_TAIL;
                end
            end
            ST_K1:
            begin
                cmd.k_op   = mm2a_pkg::K_MUL;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                cmd.k_op   = mm2a_pkg::K_MIX;
                state_next = ST_HM;
            end
            ST_HM:
            begin
                cmd.h_mul = 1'b1;
                unique case (phase_reg)
                    PH_WORD:
                        state_next = ST_IDLE;
                    PH_BLOCK:
                    begin
                        cmd.k_op   = mm2a_pkg::K_ZERO;
                        phase_next = PH_TAIL;
                        state_next = ST_K1;
                    end
                    PH_TAIL:
                    begin
                        cmd.k_op   = mm2a_pkg::K_LEN;
                        phase_next = PH_LEN;
                        state_next = ST_K1;
                    end
                    default:
                        state_next = ST_FIN;
                endcase
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit       = 1'b1;
                    in_string_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WORD;
            in_string_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            in_string_reg <= in_string_next;
        end
    end

endmodule

[rtl/murmur2a_text_hash.sv]
`timescale 1ns / 1ps

// Channel   Role    Payload                              Beat
// word_ch   sink    data_word[31:0] byte_count[2:0] last one string word
// hash_ch   source  hash_value[31:0]                     finished hash
// seed_ch   sink    hash_seed[31:0]                      seed write
//
// A non-last word is taken in the idle state and then makes three passes through
// the one shared 32x32 multiplier (k*M, (k^k>>24)*M, h*M^k).
// A last word also mixes a zero tail (full word only) and the length, then
// finalises and may wait for hash_ch to drain its output register.
// rst_n is asynchronous: seed returns to 33, no string open, no hash pending.
// word_ch stalls while a word is being mixed or its hash waits for the output register; seed_ch never stalls.

module murmur2a_text_hash (
    input  logic          clk,
    input  logic          rst_n,
    mm2a_word_if.sink     word_ch,
    mm2a_hash_if.source   hash_ch,
    mm2a_seed_if.sink     seed_ch
);

    mm2a_pkg::mm2a_cmd_t    cmd;
    mm2a_pkg::mm2a_status_t st;

    // sequencer: one mix step per cycle, tracks block/tail/length phases
    mm2a_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (word_ch.valid),
        .in_ready (word_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // hash, key and length registers, shared multiplier, output register
    mm2a_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_word  (word_ch.data_word),
        .byte_count (word_ch.byte_count),
        .last       (word_ch.last),
        .seed_valid (seed_ch.valid),
        .seed_ready (seed_ch.ready),
        .hash_seed  (seed_ch.hash_seed),
        .out_valid  (hash_ch.valid),
        .out_ready  (hash_ch.ready),
        .hash_value (hash_ch.hash_value),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

[tb/sv/murmur2a_text_hash_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the streaming MurmurHash2A block.
// Strings go in as 32-bit little-endian word beats; one hash beat comes back per string.

module murmur2a_text_hash_tb;

    // Longest job is a full last word, so this margin covers any leftover work.
    localparam int DrainCycles  = 16;
    localparam int CycleLimit   = 400000;
    localparam int PhaseWords   = 265;
    localparam int HoldOffLen   = 300;
    localparam int NumPhases    = 6;

    // One row of the directed table: a single word beat.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last_flag;
    } word_row_t;

    // Hash values cannot be read off by eye, so every row is checked against the predictor.
    localparam int NumRows = 19;
    localparam word_row_t DirectedRows [0:NumRows-1] = '{
        '{32'hffff_ffff, 3'd0, 1'b1},   // empty string, stray bytes ignored
        '{32'h0000_0000, 3'd0, 1'b1},   // empty again: seed reloaded
        '{32'hdead_beef, 3'd1, 1'b1},   // one-byte tail
        '{32'hffff_ffff, 3'd2, 1'b1},
        '{32'h8000_0001, 3'd3, 1'b1},   // top byte lies beyond the count
        '{32'h0000_0000, 3'd4, 1'b1},   // full last word, then zero tail
        '{32'hffff_ffff, 3'd4, 1'b1},
        '{32'h1234_5678, 3'd5, 1'b1},   // oversized counts clamp to four
        '{32'h1234_5678, 3'd6, 1'b1},
        '{32'h1234_5678, 3'd7, 1'b1},
        '{32'h1234_5678, 3'd4, 1'b1},
        '{32'hffff_ffff, 3'd4, 1'b0},   // multi-word string
        '{32'h0000_0000, 3'd0, 1'b0},   // short count on a body word is ignored
        '{32'ha5a5_5a5a, 3'd7, 1'b0},
        '{32'hffff_ffff, 3'd3, 1'b1},
        '{32'h0000_0000, 3'd4, 1'b0},   // zero word then empty tail
        '{32'h0000_0000, 3'd0, 1'b1},
        '{32'h6c6c_6548, 3'd4, 1'b0},   // "Hell"
        '{32'h0000_006f, 3'd1, 1'b1}    // "o"
    };

    logic clk = 1'b0;
    logic rst_n;

    mm2a_word_if word_ch ();
    mm2a_hash_if hash_ch ();
    mm2a_seed_if seed_ch ();

    murmur2a_text_hash dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .word_ch (word_ch),
        .hash_ch (hash_ch),
        .seed_ch (seed_ch)
    );

    always #5 clk = ~clk;

    // Predictor state: mirrors seed register and the open string.
    logic [31:0] seed_reg;
    logic [31:0] str_hash;
    logic [31:0] str_len;
    logic        str_open;

    logic [31:0] expected_hashes [$];

    int errors         = 0;
    int words_sent     = 0;
    int strings_sent   = 0;
    int hashes_checked = 0;
    int seed_writes    = 0;
    int cycle_count    = 0;

    // Idle odds in percent per cycle, and a long receiver hold-off on request.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;

    // One MurmurHash2 block mix: k scrambled twice through M, then folded into h*M.
    function automatic logic [31:0] mm_mix(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] kk;
        kk = k * mm2a_pkg::MmMul;
        kk = kk ^ (kk >> mm2a_pkg::MmShift);
        kk = kk * mm2a_pkg::MmMul;
        return (h * mm2a_pkg::MmMul) ^ kk;
    endfunction

    // Advances the string state by one word beat; returns 1 with the hash on the last beat.
    function automatic bit hash_word(input logic [31:0] data, input logic [2:0] count,
                                     input logic last_flag, output logic [31:0] hash_out);
        logic [2:0]  n;
        logic [31:0] h;
        logic [31:0] tail;
        if (!str_open)
        begin
            str_hash = seed_reg;
            str_len  = 32'd0;
            str_open = 1'b1;
        end
        hash_out = 32'd0;
        if (!last_flag)
        begin
            str_hash = mm_mix(str_hash, data);
            str_len  = str_len + 32'd4;
            return 1'b0;
        end
        n = (count > mm2a_pkg::FullCount) ? mm2a_pkg::FullCount : count;
        h = str_hash;
        if (n == mm2a_pkg::FullCount)
        begin
            h    = mm_mix(h, data);
            tail = 32'd0;
        end
        else
        begin
            tail = data & ((32'd1 << (int'(n) * 8)) - 32'd1);
        end
        str_len = str_len + 32'(n);
        h = mm_mix(h, tail);
        h = mm_mix(h, str_len);
        h = h ^ (h >> mm2a_pkg::FinShift1);
        h = h * mm2a_pkg::MmMul;
        h = h ^ (h >> mm2a_pkg::FinShift2);
        if (h == 32'd0)
            h = 32'd1;
        hash_out = h;
        str_hash = seed_reg;
        str_len  = 32'd0;
        str_open = 1'b0;
        return 1'b1;
    endfunction

    // Biased towards all-zero and all-one words so the extremes turn up often.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Offers one word beat from a falling edge; returns at the falling edge after acceptance.
    // valid stays high into the next call unless that call starts with an idle cycle.
    task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                             input logic last_flag);
        logic [31:0] want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            word_ch.valid = 1'b0;
            @(negedge clk);
        end
        word_ch.valid      = 1'b1;
        word_ch.data_word  = data;
        word_ch.byte_count = count;
        word_ch.last       = last_flag;
        do
            @(posedge clk);
        while (!word_ch.ready);
        words_sent++;
        if (hash_word(data, count, last_flag, want))
        begin
            expected_hashes.push_back(want);
            strings_sent++;
        end
        @(negedge clk);
    endtask

    // Mostly short strings; now and then a longer body. Body counts other than four
    // and oversized tail counts are the malformed part of the mix.
    task automatic send_random_string();
        int         body;
        logic [2:0] cnt;
        body = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(3);
        repeat (body)
        begin
            cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : mm2a_pkg::FullCount;
            send_word(rand_word(), cnt, 1'b0);
        end
        cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        send_word(rand_word(), cnt, 1'b1);
    endtask

    // Sender pause: nothing offered until every hash owed has come back.
    task automatic wait_hashes_drained();
        while (expected_hashes.size() != 0)
            @(posedge clk);
    endtask

    // Seed writes only while the block is quiet; the extra cycles cover work still in flight.
    task automatic write_seed(input logic [31:0] value);
        word_ch.valid = 1'b0;
        wait_hashes_drained();
        repeat (DrainCycles) @(posedge clk);
        @(negedge clk);
        seed_ch.valid     = 1'b1;
        seed_ch.hash_seed = value;
        do
            @(posedge clk);
        while (!seed_ch.ready);
        seed_reg = value;
        seed_writes++;
        @(negedge clk);
        seed_ch.valid = 1'b0;
    endtask

    // Receiver: ready changes on the falling edge; a hold-off request overrides the odds.
    initial
    begin : hash_receiver
        hash_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hash_ch.ready = 1'b0;
                hold_cycles   = hold_cycles - 1;
            end
            else
            begin
                hash_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every hash beat taken is matched against the oldest hash owed.
    always @(posedge clk)
    begin : hash_checker
        logic [31:0] want;
        if (rst_n && hash_ch.valid && hash_ch.ready)
        begin
            if (expected_hashes.size() == 0)
            begin
                $error("hash_value: no hash owed, got %h", hash_ch.hash_value);
                errors++;
            end
            else
            begin
                want = expected_hashes.pop_front();
                hashes_checked++;
                if (hash_ch.hash_value !== want)
                begin
                    $error("hash_value: expected %h, actual %h", want, hash_ch.hash_value);
                    errors++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("Timeout after %0d cycles, %0d hashes still owed",
                     cycle_count, expected_hashes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int phase_start;
        bit paused;

        word_ch.valid      = 1'b0;
        word_ch.data_word  = 32'd0;
        word_ch.byte_count = 3'd0;
        word_ch.last       = 1'b0;
        seed_ch.valid      = 1'b0;
        seed_ch.hash_seed  = 32'd0;
        rst_n              = 1'b0;

        seed_reg = mm2a_pkg::SeedReset;
        str_hash = mm2a_pkg::SeedReset;
        str_len  = 32'd0;
        str_open = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phases 0-1: slow receiver, phases 2-3: slow sender, phases 4-5: full rate.
        // Phase 0 runs on the reset seed; later phases cover both seed extremes and randoms.
        for (phase = 0; phase < NumPhases; phase++)
        begin
            if (phase != 0)
            begin
                write_seed(phase == 1 ? 32'h0000_0000 :
                           phase == 2 ? 32'hffff_ffff :
                           phase == 4 ? mm2a_pkg::SeedReset : $urandom);
            end
            send_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 74 : 0;
            recv_idle_pct = (phase < 2) ? 74 : (phase < 4) ? 25 : 0;

            if (phase == 0)
            begin
                for (int r = 0; r < NumRows; r++)
                    send_word(DirectedRows[r].data, DirectedRows[r].count,
                              DirectedRows[r].last_flag);
            end

            // Back-pressure: receiver frozen while one-word strings pile up,
            // so the output register fills and the word channel stalls.
            if (phase == 4)
            begin
                hold_cycles = HoldOffLen;
                repeat (30)
                    send_word(rand_word(), 3'($urandom_range(4)), 1'b1);
            end

            phase_start = words_sent;
            paused      = 1'b0;
            while (words_sent - phase_start < PhaseWords)
            begin
                send_random_string();
                if (phase == 5 && !paused && words_sent - phase_start >= PhaseWords / 2)
                begin
                    word_ch.valid = 1'b0;
                    wait_hashes_drained();
                    @(negedge clk);
                    paused = 1'b1;
                end
            end
        end

        word_ch.valid = 1'b0;
        wait_hashes_drained();
        repeat (DrainCycles) @(posedge clk);

        $display("Covered %0d word beats in %0d strings, %0d hashes checked, %0d seed writes",
                 words_sent, strings_sent, hashes_checked, seed_writes);
        $display("Idle mixes: slow receiver, slow sender, full rate; one long output hold-off");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
